// File: design/ppts_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the perspective projection pipeline.
// No dependencies.
package ppts_pkg;

	// Item function codes.
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_PROJECT = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MIN_DEPTH     = 2'd2;

	// Register field widths and reset values.
	localparam int SIZE_W  = 15;
	localparam int DEPTH_W = 17;
	localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 15'd1920;
	localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 15'd1080;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 17'd66;

	// Coefficient store shape.
	localparam int MATRIX_ENTRIES = 16;
	localparam int COEF_W         = 32;

	// The ratio magnitude is clamped to 2^RATIO_BITS.
	localparam int RATIO_BITS = 40;

	// Quotient bits resolved in each divider stage.
	localparam int DIV_BITS_PER_STAGE = 2;

endpackage

// File: design/perspective_project_to_screen.sv
`timescale 1ns / 1ps
// Perspective projection of world points to screen pixels, fully pipelined.
// Depends on ppts_pkg for codes, register defaults and divider sizing.
// The pipe has 4 front stages, 20 divider stages of two quotient bits each and
// 3 back stages.
// Throughput: one item per cycle while the result is not stalled; the two restoring dividers are unrolled into stages.
// A coefficient write takes effect at its accepting edge and gives no result.
// Reset clears the coefficient store, restores register defaults and empties the pipe.
module perspective_project_to_screen #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Item channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_y,
	input  logic signed [31:0] world_z,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	localparam int QB  = ppts_pkg::RATIO_BITS;
	localparam int BPS = ppts_pkg::DIV_BITS_PER_STAGE;
	localparam int DS  = QB / BPS;
	localparam int SW  = 66 - FRAC_BITS;     // row sum width
	localparam int RW  = SW - 1;             // divisor and remainder width
	localparam int CW  = SW + QB;            // clamp compare width
	localparam int TW  = QB + 3;             // normalized coordinate width
	localparam int MW  = TW + ppts_pkg::SIZE_W + 1;
	localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [QB-1:0] n;
		logic [QB-1:0] q;
	} div_t;

	// Resolves BPS quotient bits of a restoring division.
	function automatic div_t div_bits(div_t d, logic [RW-1:0] b);
		div_t       o;
		logic [RW:0] rs;
		o = d;
		for (int i = 0; i < BPS; i++) begin
			rs = {o.r, o.n[QB-1]};
			o.n = o.n << 1;
			if (rs >= {1'b0, b}) begin
				rs = rs - {1'b0, b};
				o.q = {o.q[QB-2:0], 1'b1};
			end else begin
				o.q = {o.q[QB-2:0], 1'b0};
			end
			o.r = rs[RW-1:0];
		end
		return o;
	endfunction

	// Pipeline advance: the whole pipe moves unless a held result is stalled.
	logic adv;
	logic accept;
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	logic [ppts_pkg::SIZE_W-1:0]  width_q, height_q;
	logic [ppts_pkg::DEPTH_W-1:0] min_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= ppts_pkg::WIDTH_RESET;
			height_q    <= ppts_pkg::HEIGHT_RESET;
			min_depth_q <= ppts_pkg::DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppts_pkg::CFG_SCREEN_WIDTH:  width_q     <= cfg_data[ppts_pkg::SIZE_W-1:0];
				ppts_pkg::CFG_SCREEN_HEIGHT: height_q    <= cfg_data[ppts_pkg::SIZE_W-1:0];
				ppts_pkg::CFG_MIN_DEPTH:     min_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficient store, written by write beats.
	logic [ppts_pkg::COEF_W-1:0] coef_q [ppts_pkg::MATRIX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppts_pkg::MATRIX_ENTRIES; i++) coef_q[i] <= '0;
		end else if (accept && func == ppts_pkg::FUNC_WRITE) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	// Valid bits for every stage.
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [DS-1:0] v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_sd <= '0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && func == ppts_pkg::FUNC_PROJECT;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd <= {v_sd[DS-2:0], v_s4};
			v_s5 <= v_sd[DS-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end
	assign out_valid = v_s7;

	// Stage 1: the nine coefficient products of rows 0, 1 and 3 and the offsets.
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] off_s1  [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int rr = 0; rr < 3; rr++) begin
				prod_s1[rr][0] <= $signed(coef_q[4'((rr == 2 ? 12 : rr * 4) + 0)]) * world_x;
				prod_s1[rr][1] <= $signed(coef_q[4'((rr == 2 ? 12 : rr * 4) + 1)]) * world_y;
				prod_s1[rr][2] <= $signed(coef_q[4'((rr == 2 ? 12 : rr * 4) + 2)]) * world_z;
				off_s1[rr]     <= $signed(coef_q[4'((rr == 2 ? 12 : rr * 4) + 3)]);
			end
		end
	end

	// Stage 2: floor-shifted products and offsets summed into px, py and w.
	logic signed [SW-1:0] sum_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int rr = 0; rr < 3; rr++) begin
				sum_s2[rr] <= $signed(SW'(prod_s1[rr][0] >>> FRAC_BITS))
					+ $signed(SW'(prod_s1[rr][1] >>> FRAC_BITS))
					+ $signed(SW'(prod_s1[rr][2] >>> FRAC_BITS))
					+ $signed(SW'(off_s1[rr]));
			end
		end
	end

	// Stage 3: visibility test and magnitudes of the numerators.
	logic          vis_s3, sx_s3, sy_s3;
	logic [SW-1:0] ax_s3, ay_s3;
	logic [RW-1:0] b_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s3 <= (sum_s2[2] > 0)
				&& (sum_s2[2] >= $signed(SW'({1'b0, min_depth_q})));
			sx_s3  <= sum_s2[0][SW-1];
			sy_s3  <= sum_s2[1][SW-1];
			ax_s3  <= sum_s2[0][SW-1] ? SW'(-sum_s2[0]) : SW'(sum_s2[0]);
			ay_s3  <= sum_s2[1][SW-1] ? SW'(-sum_s2[1]) : SW'(sum_s2[1]);
			b_s3   <= RW'(sum_s2[2]);
		end
	end

	// Stage 4: clamp detection and divider setup.
	logic          vis_s4, sx_s4, sy_s4, clx_s4, cly_s4;
	logic [RW-1:0] b_s4;
	div_t          dx_s4, dy_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s4 <= vis_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			b_s4   <= b_s3;
			clx_s4 <= CW'(ax_s3) >= (CW'(b_s3) << (QB - FRAC_BITS));
			cly_s4 <= CW'(ay_s3) >= (CW'(b_s3) << (QB - FRAC_BITS));
			dx_s4  <= '{r: RW'(ax_s3 >> (QB - FRAC_BITS)),
				n: QB'(CW'(ax_s3) << FRAC_BITS), q: '0};
			dy_s4  <= '{r: RW'(ay_s3 >> (QB - FRAC_BITS)),
				n: QB'(CW'(ay_s3) << FRAC_BITS), q: '0};
		end
	end

	// Divider stages: each resolves BPS quotient bits for both coordinates.
	div_t          dx_sd [DS];
	div_t          dy_sd [DS];
	logic [RW-1:0] b_sd  [DS];
	logic          vis_sd [DS], sx_sd [DS], sy_sd [DS], clx_sd [DS], cly_sd [DS];

	for (genvar k = 0; k < DS; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					dx_sd[k]  <= div_bits(dx_s4, b_s4);
					dy_sd[k]  <= div_bits(dy_s4, b_s4);
					b_sd[k]   <= b_s4;
					vis_sd[k] <= vis_s4;
					sx_sd[k]  <= sx_s4;
					sy_sd[k]  <= sy_s4;
					clx_sd[k] <= clx_s4;
					cly_sd[k] <= cly_s4;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					dx_sd[k]  <= div_bits(dx_sd[k-1], b_sd[k-1]);
					dy_sd[k]  <= div_bits(dy_sd[k-1], b_sd[k-1]);
					b_sd[k]   <= b_sd[k-1];
					vis_sd[k] <= vis_sd[k-1];
					sx_sd[k]  <= sx_sd[k-1];
					sy_sd[k]  <= sy_sd[k-1];
					clx_sd[k] <= clx_sd[k-1];
					cly_sd[k] <= cly_sd[k-1];
				end
			end
		end
	end

	// Stage 5: clamp, sign and offset by one.
	logic [QB:0]          qx, qy;
	logic signed [TW-1:0] nx, ny;
	logic signed [TW-1:0] tx_s5, ty_s5;
	logic                 vis_s5;

	always_comb begin
		qx = clx_sd[DS-1] ? (QB+1)'(1) << QB : {1'b0, dx_sd[DS-1].q};
		qy = cly_sd[DS-1] ? (QB+1)'(1) << QB : {1'b0, dy_sd[DS-1].q};
		nx = sx_sd[DS-1] ? -$signed(TW'(qx)) : $signed(TW'(qx));
		ny = sy_sd[DS-1] ? -$signed(TW'(qy)) : $signed(TW'(qy));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s5 <= vis_sd[DS-1];
			tx_s5  <= ONE + nx;
			ty_s5  <= ONE - ny;
		end
	end

	// Stage 6: scale by the viewport size.
	logic signed [MW-1:0] mx_s6, my_s6;
	logic                 vis_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s6 <= vis_s5;
			mx_s6  <= $signed({1'b0, width_q}) * tx_s5;
			my_s6  <= $signed({1'b0, height_q}) * ty_s5;
		end
	end

	// Stage 7: halve with floor, saturate to 32 bits, zero when not visible.
	function automatic logic signed [31:0] sat_half(logic signed [MW-1:0] m);
		logic signed [MW-1:0] h;
		h = m >>> 1;
		if (h > $signed(MW'(32'sh7FFF_FFFF)))
			return 32'sh7FFF_FFFF;
		else if (h < $signed(MW'(-33'sd2147483648)))
			return 32'sh8000_0000;
		else
			return 32'(h);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			visible  <= vis_s6;
			screen_x <= vis_s6 ? sat_half(mx_s6) : '0;
			screen_y <= vis_s6 ? sat_half(my_s6) : '0;
		end
	end

	// A hidden point always reports zero coordinates.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> screen_x == 0 && screen_y == 0)
		else $error("hidden point with nonzero coordinates");

	// A coefficient write never enters the arithmetic pipe.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == ppts_pkg::FUNC_WRITE |=> !v_s1)
		else $error("coefficient write produced a pipeline item");

	// While the result is stalled the whole pipe holds.
	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> v_s1 == $past(v_s1) && v_sd == $past(v_sd))
		else $error("pipeline moved during a stall");

endmodule
